@@ rtl/icts_pkg.sv @@
package icts_pkg;

    localparam int CDF_W   = 17;
    localparam int SUP_W   = 16;
    localparam int IDX_W   = 10;
    localparam int SIZE_W  = 11;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic                    action;
        logic [IDX_W-1:0]        entry_index;
        logic [CDF_W-1:0]        cdf_value;
        logic signed [SUP_W-1:0] support_value;
        logic [CDF_W-1:0]        uniform;
        logic                    final_draw;
    } in_item_t;

    typedef struct packed {
        logic signed [SUP_W-1:0] sample_value;
        logic [IDX_W-1:0]        selected_index;
        logic                    batch_end;
    } out_item_t;

endpackage

@@ rtl/inverse_cdf_table_sampler_top.sv @@
// Inverse-transform sampler over a loaded CDF table.
//
// Input channel (s_valid/s_ready/s_data): a load item (action = load) writes
// one entry of the CDF and support tables in the cycle it is accepted and
// gives no result; loads beyond TABLE_DEPTH are dropped. A sample item starts
// a linear scan of the table from entry 0, one entry per cycle through the
// single read port of the table RAM (registered read).
// Result channel (m_valid/m_ready/m_data): one item per sample, held in an
// output register. A sample visits at most table_size entries (at least one,
// and at most TABLE_DEPTH); no new item is taken until its scan has ended
// and its result is in the output register.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): writes table_size,
// always ready; write it only while the block is idle.
// Reset (aresetn low, synchronous) returns to idle, drops any pending result
// and sets table_size to 1024. Table contents are not cleared and must be
// loaded before they are sampled.
// When the receiver stalls, the result waits in the output register while the
// block keeps taking items; a scan that finishes before the slot frees holds
// its last entry until the pending result is taken.
module inverse_cdf_table_sampler_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  icts_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output icts_pkg::out_item_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [icts_pkg::SIZE_W-1:0]        cfg_data
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int ENT_W = icts_pkg::CDF_W + icts_pkg::SUP_W;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Last entry the scan may visit for a given table_size.
    function automatic logic [AW-1:0] last_of(input logic [icts_pkg::SIZE_W-1:0] n);
        int eff;
        eff = (n == '0) ? 1 : int'(n);
        if (eff > TABLE_DEPTH) begin
            eff = TABLE_DEPTH;
        end
        return AW'(eff - 1);
    endfunction

    state_t                           state_reg, state_next;
    logic [AW-1:0]                    last_reg, last_next;
    logic [AW-1:0]                    chk_reg, chk_next;
    logic [AW-1:0]                    pos_reg, pos_next;
    logic [icts_pkg::CDF_W-1:0]       prev_reg, prev_next;
    logic [icts_pkg::CDF_W-1:0]       u_reg, u_next;
    logic                             fin_reg, fin_next;
    logic signed [icts_pkg::SUP_W-1:0] sup_reg, sup_next;
    logic                             m_valid_reg, m_valid_next;
    icts_pkg::out_item_t              out_reg, out_next;

    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr, ram_raddr;
    logic [ENT_W-1:0]                 ram_wdata, ram_rdata;
    logic [icts_pkg::CDF_W-1:0]       rd_cdf;
    logic signed [icts_pkg::SUP_W-1:0] rd_sup;
    logic [icts_pkg::CDF_W-1:0]       cur_gap;
    logic                             take, done, out_free, s_fire;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign ram_we    = s_fire && (s_data.action == icts_pkg::ACT_LOAD)
                       && (32'(s_data.entry_index) < TABLE_DEPTH);
    assign ram_waddr = AW'(s_data.entry_index);
    assign ram_wdata = {s_data.cdf_value, s_data.support_value};

    icts_ram #(
        .WIDTH(ENT_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_cdf  = ram_rdata[ENT_W-1:icts_pkg::SUP_W];
    assign rd_sup  = ram_rdata[icts_pkg::SUP_W-1:0];
    assign cur_gap = (u_reg >= rd_cdf) ? (u_reg - rd_cdf) : (rd_cdf - u_reg);
    assign take    = (chk_reg == '0) || (prev_reg > cur_gap);
    assign done    = !take || (chk_reg == last_reg);

    // Read entry 0 while idle; in a scan read ahead, or re-read when stalled.
    always_comb begin
        case (state_reg)
            ST_IDLE: ram_raddr = '0;
            ST_SCAN: ram_raddr = (done && !out_free) ? chk_reg : chk_reg + 1'b1;
            default: ram_raddr = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        last_next    = last_reg;
        chk_next     = chk_reg;
        pos_next     = pos_reg;
        prev_next    = prev_reg;
        u_next       = u_reg;
        fin_next     = fin_reg;
        sup_next     = sup_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_valid && cfg_ready) begin
            last_next = last_of(cfg_data);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.action == icts_pkg::ACT_SAMPLE)) begin
                    u_next     = s_data.uniform;
                    fin_next   = s_data.final_draw;
                    chk_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (done) begin
                    if (out_free) begin
                        out_next.sample_value   = take ? rd_sup : sup_reg;
                        out_next.selected_index = icts_pkg::IDX_W'(take ? chk_reg : pos_reg);
                        out_next.batch_end      = fin_reg;
                        m_valid_next            = 1'b1;
                        state_next              = ST_IDLE;
                    end
                end else begin
                    prev_next = cur_gap;
                    pos_next  = chk_reg;
                    sup_next  = rd_sup;
                    chk_next  = chk_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            last_reg    <= last_of(icts_pkg::SIZE_RESET);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            last_reg    <= last_next;
        end
        chk_reg  <= chk_next;
        pos_reg  <= pos_next;
        prev_reg <= prev_next;
        u_reg    <= u_next;
        fin_reg  <= fin_next;
        sup_reg  <= sup_next;
        out_reg  <= out_next;
    end

    a_chk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (chk_reg <= last_reg))
        else $error("scan index beyond last entry");

    a_pos_behind_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && (chk_reg != '0) |-> (pos_reg < chk_reg))
        else $error("kept entry not behind scan index");

    a_sample_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.action == icts_pkg::ACT_SAMPLE)
        |=> (state_reg == ST_SCAN) && (chk_reg == '0))
        else $error("sample item did not start a scan");

    a_result_ends_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && done && out_free |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("finished scan did not post its result");

endmodule

@@ rtl/icts_ram.sv @@
module icts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
